>>> sv/ps_pkg.sv
// Package for the prime sieve unit: sizes, widths and sequencer state type.
package ps_pkg;

    localparam int MAX_LIMIT      = 65536;
    localparam int PRIME_CAPACITY = 8192;

    localparam int LIMIT_W = 17;
    localparam int IDX_W   = 13;
    localparam int COUNT_W = 14;

    localparam int MAP_DEPTH = MAX_LIMIT + 1;
    localparam int MAP_AW    = $clog2(MAP_DEPTH);
    localparam int LIST_AW   = $clog2(PRIME_CAPACITY);
    localparam int SQ_W      = 2 * LIMIT_W;
    localparam int ALU_W     = LIMIT_W + 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_MARK,
        ST_ADV,
        ST_RD_DATA,
        ST_FIN
    } ps_state_t;

endpackage

>>> sv/ps_if.sv
// Valid/ready channel interfaces for command and result words.
interface ps_in_if;
    logic                        valid;
    logic                        ready;
    logic                        kind;
    logic [ps_pkg::LIMIT_W-1:0]  upper_limit;
    logic [ps_pkg::IDX_W-1:0]    prime_index;

    modport source (output valid, output kind, output upper_limit, output prime_index,
                    input ready);
    modport sink   (input valid, input kind, input upper_limit, input prime_index,
                    output ready);
endinterface

interface ps_out_if;
    logic                        valid;
    logic                        ready;
    logic [ps_pkg::COUNT_W-1:0]  num_primes;
    logic [ps_pkg::LIMIT_W-1:0]  prime_value;
    logic                        found;

    modport source (output valid, output num_primes, output prime_value, output found,
                    input ready);
    modport sink   (input valid, input num_primes, input prime_value, input found,
                    output ready);
endinterface

>>> sv/ps_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ps_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/prime_sieve_unit.sv
// Top level: sieve of Eratosthenes engine with stored ascending prime list.
//
//   channel | dir | words
//   --------+-----+---------------------------------------------
//   in      | in  | kind, upper_limit, prime_index
//   out     | out | num_primes, prime_value, found
//
// Sieve word: clear the bitmap entries 0..L (L = saturated limit), then for each
// candidate 2..L read, check and advance, marking the multiples of each prime from its
// square, then FIN; all through the one bitmap RAM. Read word: RD_DATA, then FIN.
// Reset clears the sequencer, count and output valid; RAM contents need no reset.
// in.ready is high only while idle; a finished result waits in the output register.
module prime_sieve_unit (
    input  logic     clk,
    input  logic     rst_n,
    ps_in_if.sink    in,
    ps_out_if.source out
);

    ps_pkg::ps_state_t state_reg, state_next;

    logic [ps_pkg::LIMIT_W-1:0] lim_reg,   lim_next;
    logic [ps_pkg::LIMIT_W-1:0] p_reg,     p_next;
    logic [ps_pkg::LIMIT_W-1:0] addr_reg,  addr_next;
    logic [ps_pkg::SQ_W-1:0]    sq_reg,    sq_next;
    logic [ps_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [ps_pkg::IDX_W-1:0]   idx_reg,   idx_next;
    logic [ps_pkg::LIMIT_W-1:0] res_value_reg, res_value_next;
    logic                       res_found_reg, res_found_next;

    logic                       out_valid_reg, out_valid_next;
    logic [ps_pkg::COUNT_W-1:0] out_count_reg, out_count_next;
    logic [ps_pkg::LIMIT_W-1:0] out_value_reg, out_value_next;
    logic                       out_found_reg, out_found_next;

    logic                        map_we;
    logic                        map_wdata;
    logic [ps_pkg::MAP_AW-1:0]   map_raddr;
    logic                        map_rdata;
    logic                        list_we;
    logic [ps_pkg::LIMIT_W-1:0]  list_rdata;

    logic [ps_pkg::LIMIT_W-1:0]  alu_a, alu_b;
    logic [ps_pkg::ALU_W-1:0]    alu_sum;
    logic [ps_pkg::LIMIT_W-1:0]  sat_limit;
    logic                        accept;
    logic                        fin_load;
    logic                        list_room;
    logic                        sq_in_range;
    logic                        mark_over;

    assign accept   = in.valid && in.ready;
    assign in.ready = (state_reg == ps_pkg::ST_IDLE);
    assign fin_load = (state_reg == ps_pkg::ST_FIN) && (!out_valid_reg || out.ready);

    assign sat_limit = (in.upper_limit > ps_pkg::LIMIT_W'(ps_pkg::MAX_LIMIT))
                     ? ps_pkg::LIMIT_W'(ps_pkg::MAX_LIMIT) : in.upper_limit;

    // shared adder: clear and mark address steps, candidate increment
    assign alu_a   = (state_reg == ps_pkg::ST_ADV) ? p_reg : addr_reg;
    assign alu_b   = (state_reg == ps_pkg::ST_MARK) ? p_reg : ps_pkg::LIMIT_W'(1);
    assign alu_sum = {1'b0, alu_a} + {1'b0, alu_b};

    assign list_room   = (count_reg < ps_pkg::COUNT_W'(ps_pkg::PRIME_CAPACITY));
    assign sq_in_range = (sq_reg <= ps_pkg::SQ_W'(lim_reg));
    assign mark_over   = (alu_sum > {1'b0, lim_reg});

    ps_ram #(
        .WIDTH (1),
        .DEPTH (ps_pkg::MAP_DEPTH)
    ) u_map (
        .clk   (clk),
        .we    (map_we),
        .waddr (addr_reg),
        .wdata (map_wdata),
        .raddr (map_raddr),
        .rdata (map_rdata)
    );

    ps_ram #(
        .WIDTH (ps_pkg::LIMIT_W),
        .DEPTH (ps_pkg::PRIME_CAPACITY)
    ) u_list (
        .clk   (clk),
        .we    (list_we),
        .waddr (count_reg[ps_pkg::LIST_AW-1:0]),
        .wdata (p_reg),
        .raddr (in.prime_index),
        .rdata (list_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ps_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = in.kind ? ps_pkg::ST_RD_DATA : ps_pkg::ST_CLEAR;
                end
            end
            ps_pkg::ST_CLEAR:
            begin
                if (addr_reg == lim_reg)
                begin
                    state_next = (lim_reg < ps_pkg::LIMIT_W'(2)) ? ps_pkg::ST_FIN
                                                               : ps_pkg::ST_SCAN_RD;
                end
            end
            ps_pkg::ST_SCAN_RD:  state_next = ps_pkg::ST_SCAN_CHK;
            ps_pkg::ST_SCAN_CHK:
            begin
                state_next = (!map_rdata && sq_in_range) ? ps_pkg::ST_MARK : ps_pkg::ST_ADV;
            end
            ps_pkg::ST_MARK:
            begin
                if (mark_over)
                begin
                    state_next = ps_pkg::ST_ADV;
                end
            end
            ps_pkg::ST_ADV:
            begin
                state_next = (p_reg == lim_reg) ? ps_pkg::ST_FIN : ps_pkg::ST_SCAN_RD;
            end
            ps_pkg::ST_RD_DATA:  state_next = ps_pkg::ST_FIN;
            ps_pkg::ST_FIN:
            begin
                if (fin_load)
                begin
                    state_next = ps_pkg::ST_IDLE;
                end
            end
        endcase
    end

    // datapath and RAM controls
    always_comb
    begin
        lim_next       = lim_reg;
        p_next         = p_reg;
        addr_next      = addr_reg;
        sq_next        = sq_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        res_value_next = res_value_reg;
        res_found_next = res_found_reg;
        map_we         = 1'b0;
        map_wdata      = 1'b0;
        map_raddr      = p_reg;
        list_we        = 1'b0;

        out_valid_next = out_valid_reg;
        out_count_next = out_count_reg;
        out_value_next = out_value_reg;
        out_found_next = out_found_reg;
        if (out_valid_reg && out.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ps_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    idx_next       = in.prime_index;
                    res_value_next = '0;
                    res_found_next = 1'b0;
                    if (!in.kind)
                    begin
                        lim_next   = sat_limit;
                        addr_next  = '0;
                        count_next = '0;
                        p_next     = ps_pkg::LIMIT_W'(2);
                        sq_next    = ps_pkg::SQ_W'(4);
                    end
                end
            end
            ps_pkg::ST_CLEAR:
            begin
                map_we    = 1'b1;
                map_wdata = (addr_reg < ps_pkg::LIMIT_W'(2));
                addr_next = alu_sum[ps_pkg::LIMIT_W-1:0];
            end
            ps_pkg::ST_SCAN_RD:
            begin
                map_raddr = p_reg;
            end
            ps_pkg::ST_SCAN_CHK:
            begin
                if (!map_rdata)
                begin
                    if (list_room)
                    begin
                        list_we    = 1'b1;
                        count_next = count_reg + ps_pkg::COUNT_W'(1);
                    end
                    addr_next = sq_reg[ps_pkg::LIMIT_W-1:0];
                end
            end
            ps_pkg::ST_MARK:
            begin
                map_we    = 1'b1;
                map_wdata = 1'b1;
                addr_next = alu_sum[ps_pkg::LIMIT_W-1:0];
            end
            ps_pkg::ST_ADV:
            begin
                if (p_reg != lim_reg)
                begin
                    p_next  = alu_sum[ps_pkg::LIMIT_W-1:0];
                    sq_next = sq_reg + ps_pkg::SQ_W'({p_reg, 1'b1});
                end
            end
            ps_pkg::ST_RD_DATA:
            begin
                res_found_next = (ps_pkg::COUNT_W'(idx_reg) < count_reg);
                res_value_next = res_found_next ? list_rdata : '0;
            end
            ps_pkg::ST_FIN:
            begin
                if (fin_load)
                begin
                    out_valid_next = 1'b1;
                    out_count_next = count_reg;
                    out_value_next = res_value_reg;
                    out_found_next = res_found_reg;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ps_pkg::ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lim_reg       <= lim_next;
        p_reg         <= p_next;
        addr_reg      <= addr_next;
        sq_reg        <= sq_next;
        idx_reg       <= idx_next;
        res_value_reg <= res_value_next;
        res_found_reg <= res_found_next;
        out_count_reg <= out_count_next;
        out_value_reg <= out_value_next;
        out_found_reg <= out_found_next;
    end

    assign out.valid       = out_valid_reg;
    assign out.num_primes  = out_count_reg;
    assign out.prime_value = out_value_reg;
    assign out.found       = out_found_reg;

`ifndef SYNTHESIS
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= ps_pkg::COUNT_W'(ps_pkg::PRIME_CAPACITY))
        else $error("prime count above capacity");

    a_mark_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ps_pkg::ST_MARK) |-> (addr_reg <= lim_reg && addr_reg > p_reg))
        else $error("mark address out of range");

    a_cand_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ps_pkg::ST_SCAN_CHK) |-> (p_reg >= ps_pkg::LIMIT_W'(2)
                                               && p_reg <= lim_reg))
        else $error("candidate out of range");

    a_found_prime: assert property (@(posedge clk) disable iff (!rst_n)
        (out.valid && out.found) |-> (out.prime_value >= ps_pkg::LIMIT_W'(2)))
        else $error("found result without a prime value");
`endif

endmodule
